// ----- hw/rtl/plc_pkg.sv -----
// Shared types and constants of the per-client limit counter.
`timescale 1ns / 1ps
package plc_pkg;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_REG   = 3'd3;
  localparam logic [2:0] OP_UNREG = 3'd4;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [31:0] DEFAULT_LIMIT = 32'd10000;

  localparam logic REG_LIMIT  = 1'b0;
  localparam logic REG_ONLINE = 1'b1;

  // Request from the sequencer to the shared divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [6:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// ----- hw/rtl/plc_div.sv -----
// Restoring divider, one quotient bit per cycle, used for headroom sharing.
`timescale 1ns / 1ps
module plc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  plc_pkg::div_req_t req,
  output plc_pkg::div_rsp_t rsp
);

  logic [31:0] quo_r, quo_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [6:0]  dsr_r, dsr_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = (req.divisor == 7'd0) ? 7'd1 : req.divisor;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it fits in seven bits.
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = 7'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[6:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- hw/rtl/per_client_limit_counter_top.sv -----
// Top level of the per-client limit counter: slot store, sequencer and ports.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tdata {delta, client_id, opcode}
//  out_    | out | out_tvalid/tready   | tdata {total, success}
//  cfg_    | in  | APB psel/penable    | global_limit, online_clients
//
// After acceptance the item passes S_EXEC; a fast-path add or subtract, register and
// unknown op then go to S_OUT, unregister passes S_FOLD first, and a read walks
// S_FLUSH (one slot summed a cycle). A slow path folds the slot, may flush every slot
// one client per cycle, then runs the shared divider (S_DIV, S_WAIT) until the result.
// The sequencer idles again once the result is taken. in_tready is low while an item
// is at work or its result waits; a stall on out_ holds the result. Reset is synchronous.
`timescale 1ns / 1ps
module per_client_limit_counter_top #(
  parameter int NUM_CLIENTS = 8,
  parameter int LOCAL_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode[2:0], client_id[8:3], delta[40:9], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // success[0], total[32:1], zero fill
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam logic [31:0] LOCAL_MAX = 32'((64'd1 << LOCAL_BITS) - 64'd1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EXEC  = 8'b0000_0010,
    S_FOLD  = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_FLUSH = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_WAIT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [LOCAL_BITS-1:0] lcnt_r [NUM_CLIENTS];
  logic [LOCAL_BITS-1:0] lres_r [NUM_CLIENTS];
  logic [NUM_CLIENTS-1:0] act_r, act_nxt;
  logic [31:0] gcnt_r, gcnt_nxt, gres_r, gres_nxt;
  logic [31:0] limit_r, limit_nxt;
  logic [6:0]  online_r, online_nxt;

  logic [2:0]  op_r, op_nxt;
  logic [IW-1:0] id_r, id_nxt;
  logic        idok_r, idok_nxt;
  logic [31:0] delta_r, delta_nxt;
  logic        flushed_r, flushed_nxt;
  logic [IW:0] idx_r, idx_nxt;
  logic        succ_r, succ_nxt;
  logic [31:0] total_r, total_nxt;

  // One slot write per cycle.
  logic                  sw_en;
  logic [IW-1:0]         sw_idx;
  logic [LOCAL_BITS-1:0] sw_cnt, sw_res;

  plc_pkg::div_req_t dreq;
  plc_pkg::div_rsp_t drsp;

  plc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [5:0]  in_id;
  logic [31:0] lc, lr, fl_c, fl_r;
  logic [32:0] usum;
  logic [31:0] room;
  logic [32:0] sum33;
  logic [31:0] cm, half;
  logic [IW-1:0] fidx;
  logic        cfg_wr;

  assign in_id  = in_tdata[8:3];
  assign lc     = 32'(lcnt_r[id_r]);
  assign lr     = 32'(lres_r[id_r]);
  assign fidx   = idx_r[IW-1:0];
  assign fl_c   = 32'(lcnt_r[fidx]);
  assign fl_r   = 32'(lres_r[fidx]);
  assign usum   = {1'b0, gcnt_r} + {1'b0, gres_r};
  assign room   = (usum >= {1'b0, limit_r}) ? 32'd0 : 32'({1'b0, limit_r} - usum);
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    gcnt_nxt    = gcnt_r;
    gres_nxt    = gres_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    idok_nxt    = idok_r;
    delta_nxt   = delta_r;
    flushed_nxt = flushed_r;
    idx_nxt     = idx_r;
    succ_nxt    = succ_r;
    total_nxt   = total_r;
    sw_en       = 1'b0;
    sw_idx      = id_r;
    sw_cnt      = '0;
    sw_res      = '0;
    dreq.start    = 1'b0;
    dreq.dividend = room;
    dreq.divisor  = online_r;
    sum33 = '0;
    cm    = '0;
    half  = '0;
    limit_nxt  = limit_r;
    online_nxt = online_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        plc_pkg::REG_LIMIT:  limit_nxt  = cfg_pwdata;
        plc_pkg::REG_ONLINE: online_nxt = cfg_pwdata[6:0];
        default: ;
      endcase
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt      = in_tdata[2:0];
          id_nxt      = IW'(in_id);
          idok_nxt    = {26'd0, in_id} < NUM_CLIENTS;
          delta_nxt   = in_tdata[40:9];
          flushed_nxt = 1'b0;
          idx_nxt     = '0;
          total_nxt   = '0;
          succ_nxt    = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        case (op_r)
          plc_pkg::OP_ADD: begin
            if (!idok_r) succ_nxt = 1'b0;
            else if (delta_r <= LOCAL_MAX &&
                     ({1'b0, lc} + {1'b0, delta_r}) <= {1'b0, lr}) begin
              sw_en = 1'b1; sw_cnt = LOCAL_BITS'(lc + delta_r); sw_res = lres_r[id_r];
            end else state_nxt = S_FOLD;
          end
          plc_pkg::OP_SUB: begin
            if (!idok_r) succ_nxt = 1'b0;
            else if (delta_r <= lc) begin
              sw_en = 1'b1; sw_cnt = LOCAL_BITS'(lc - delta_r); sw_res = lres_r[id_r];
            end else state_nxt = S_FOLD;
          end
          plc_pkg::OP_READ: begin
            total_nxt = gcnt_r;
            state_nxt = S_FLUSH;
          end
          plc_pkg::OP_REG: if (idok_r) act_nxt[id_r] = 1'b1;
          plc_pkg::OP_UNREG: if (idok_r) begin
            state_nxt = S_FOLD;
          end
          default: ;
        endcase
      end
      S_FOLD: begin
        sum33    = {1'b0, gcnt_r} + {1'b0, lc};
        gcnt_nxt = sum33[32] ? plc_pkg::MAX32 : sum33[31:0];
        gres_nxt = (lr > gres_r) ? 32'd0 : gres_r - lr;
        sw_en    = 1'b1;
        if (op_r == plc_pkg::OP_UNREG) begin
          act_nxt[id_r] = 1'b0;
          state_nxt = S_OUT;
        end else state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if ((op_r == plc_pkg::OP_ADD) ? (room < delta_r) : (gcnt_r < delta_r)) begin
          if (!flushed_r && gres_r != 32'd0) begin
            flushed_nxt = 1'b1;
            idx_nxt     = '0;
            state_nxt   = S_FLUSH;
          end else begin
            succ_nxt  = 1'b0;
            state_nxt = S_OUT;
          end
        end else begin
          if (op_r == plc_pkg::OP_ADD) begin
            sum33    = {1'b0, gcnt_r} + {1'b0, delta_r};
            gcnt_nxt = sum33[32] ? plc_pkg::MAX32 : sum33[31:0];
          end else gcnt_nxt = gcnt_r - delta_r;
          state_nxt = S_DIV;
        end
      end
      S_FLUSH: begin
        // Shared walk: folds slots on the slow path, sums them for a read.
        if (act_r[fidx]) begin
          if (op_r == plc_pkg::OP_READ) begin
            sum33     = {1'b0, total_r} + {1'b0, fl_c};
            total_nxt = sum33[32] ? plc_pkg::MAX32 : sum33[31:0];
          end else begin
            sum33    = {1'b0, gcnt_r} + {1'b0, fl_c};
            gcnt_nxt = sum33[32] ? plc_pkg::MAX32 : sum33[31:0];
            gres_nxt = (fl_r > gres_r) ? 32'd0 : gres_r - fl_r;
            sw_en = 1'b1; sw_idx = fidx;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (IW+1)'(NUM_CLIENTS - 1))
          state_nxt = (op_r == plc_pkg::OP_READ) ? S_OUT : S_CHECK;
      end
      S_DIV: begin
        dreq.start = 1'b1;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        if (drsp.done) begin
          cm       = (drsp.quotient > LOCAL_MAX) ? LOCAL_MAX : drsp.quotient;
          sum33    = {1'b0, gres_r} + {1'b0, cm};
          gres_nxt = sum33[32] ? plc_pkg::MAX32 : sum33[31:0];
          half     = {1'b0, cm[31:1]};
          if (half > gcnt_r) half = gcnt_r;
          gcnt_nxt = gcnt_r - half;
          sw_en = 1'b1; sw_cnt = LOCAL_BITS'(half); sw_res = LOCAL_BITS'(cm);
          state_nxt = S_OUT;
        end
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      act_r    <= '0;
      gcnt_r   <= '0;
      gres_r   <= '0;
      limit_r  <= plc_pkg::DEFAULT_LIMIT;
      online_r <= 7'd1;
      for (int k = 0; k < NUM_CLIENTS; k++) begin
        lcnt_r[k] <= '0;
        lres_r[k] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      act_r    <= act_nxt;
      gcnt_r   <= gcnt_nxt;
      gres_r   <= gres_nxt;
      limit_r  <= limit_nxt;
      online_r <= online_nxt;
      if (sw_en) begin
        lcnt_r[sw_idx] <= sw_cnt;
        lres_r[sw_idx] <= sw_res;
      end
    end
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    idok_r    <= idok_nxt;
    delta_r   <= delta_nxt;
    flushed_r <= flushed_nxt;
    idx_r     <= idx_nxt;
    succ_r    <= succ_nxt;
    total_r   <= total_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {7'd0, total_r, succ_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? {25'd0, online_r} : limit_r;

endmodule

// ----- hw/rtl/plc_checker.sv -----
// Port-level checker for the per-client limit counter, bound to the top level.
`timescale 1ns / 1ps
module plc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // A result waiting for the sink holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // No new request is taken while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("ready while result pending");

  // An accepted request never yields a result in the very next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid && !in_tready)
    else $error("request not held for work");

  // The fill bits above the total stay zero on every result.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] == 7'd0)
    else $error("pad bits set");

endmodule

bind per_client_limit_counter_top plc_checker u_plc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
